/* design/kv_request_frame_parser_assert.svh */
// assertion macros shared by the request parser rtl
// used inside modules only, no other dependencies
`ifndef KV_REQUEST_FRAME_PARSER_ASSERT_SVH
`define KV_REQUEST_FRAME_PARSER_ASSERT_SVH

// property checked at every clock edge outside reset
`define KVRFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define KVRFP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* design/kvrfp_pkg.sv */
// codes, widths and field indexes of the key-value request parser
// no dependencies
package kvrfp_pkg;

   localparam int DATA_BITS     = 8;
   localparam int WORD_BITS     = 64;
   localparam int RSP_DATA_BITS = 208;

   localparam logic [2:0] STATUS_NEED_MORE   = 3'd0;
   localparam logic [2:0] STATUS_COMPLETE    = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
   localparam logic [2:0] STATUS_BAD_COMMAND = 3'd3;
   localparam logic [2:0] STATUS_DROPPED     = 3'd4;

   localparam logic [2:0] KIND_VERSION   = 3'd0;
   localparam logic [2:0] KIND_COMMAND   = 3'd1;
   localparam logic [2:0] KIND_FLAGS     = 3'd2;
   localparam logic [2:0] KIND_KEY_LEN   = 3'd3;
   localparam logic [2:0] KIND_KEY_BYTE  = 3'd4;
   localparam logic [2:0] KIND_VALUE_LEN = 3'd5;
   localparam logic [2:0] KIND_VALUE_BYTE = 3'd6;

   localparam logic [1:0] CMD_NOP = 2'd0;
   localparam logic [1:0] CMD_GET = 2'd1;
   localparam logic [1:0] CMD_PUT = 2'd2;

   localparam logic [2:0] CMD_LAST_INDEX  = 3'd3;
   localparam logic [2:0] WORD_LAST_INDEX = 3'd7;

   localparam logic [DATA_BITS-1:0] VERSION_OK = 8'd0;
   localparam logic [DATA_BITS-1:0] BYTE_ZERO  = 8'd0;

endpackage

/* design/kv_request_frame_parser.sv */
// key-value request frame parser, top level and only module
// depends on kvrfp_pkg and kv_request_frame_parser_assert.svh

// Parses a key-value request stream one byte per transfer: a version byte (must be 0),
// a 4-byte big-endian command (nop, get, put), 8-byte flags, an 8-byte key length, the
// key bytes and, for nop and put, an 8-byte value length and the value bytes. Every input
// transfer yields exactly one output transfer that classifies the byte, passes it through
// and reports the running header values; a zero length is read again from the next 8
// bytes. A bad version or command latches an error and every later byte reports dropped
// until a byte arrives with the new-connection flag set, which clears the parser first.
// Throughput is one byte per clock cycle while the output is read: the parser state
// is updated by one short step between the state registers and the output register, and
// a new byte is taken whenever the output register is empty or being read in that cycle.
// Lengths keep their low LENGTH_BITS bits and are reported zero-extended to 64 bits.

`include "kv_request_frame_parser_assert.svh"

module kv_request_frame_parser
   import kvrfp_pkg::*;
#(
   parameter int LENGTH_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DATA_BITS-1:0]     req_tdata,   // data_byte
   input  logic                     req_tuser,   // new_connection
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // status, byte_out, command_code, request_flags, key_length, value_length, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [2:0]               rsp_tuser,   // field_kind
   output logic                     rsp_tlast    // field_last
);

   typedef enum logic [2:0] {
      PH_VERSION,
      PH_COMMAND,
      PH_FLAGS,
      PH_KEYLEN,
      PH_KEY,
      PH_VALLEN,
      PH_VALUE
   } phase_type;

   typedef logic [LENGTH_BITS-1:0] len_type;

   phase_type             phase_ff, phase_in, cur_phase;
   logic [2:0]            count_ff, count_in, cur_count;
   logic [1:0]            command_ff, command_in, cur_command;
   logic [WORD_BITS-1:0]  flags_ff, flags_in, cur_flags;
   len_type               key_len_ff, key_len_in, cur_key_len;
   len_type               key_left_ff, key_left_in, cur_key_left;
   len_type               val_len_ff, val_len_in, cur_val_len;
   len_type               val_left_ff, val_left_in, cur_val_left;
   logic                  error_ff, error_in, cur_error;
   logic                  cmd_high_ff, cmd_high_in, cur_cmd_high;

   logic                  rsp_valid_ff;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [2:0]            rsp_kind_ff, rsp_kind_in;
   logic [DATA_BITS-1:0]  rsp_byte_ff;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic [DATA_BITS-1:0]  data_byte;
   logic [WORD_BITS-1:0]  flags_base;
   len_type               key_len_base, val_len_base, key_left_dec, val_left_dec;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign data_byte  = req_tdata;

   // a new connection clears the parser before the byte is taken
   always_comb begin
      if (req_tuser) begin
         cur_phase    = PH_VERSION;
         cur_count    = '0;
         cur_command  = CMD_NOP;
         cur_flags    = '0;
         cur_key_len  = '0;
         cur_key_left = '0;
         cur_val_len  = '0;
         cur_val_left = '0;
         cur_error    = 1'b0;
         cur_cmd_high = 1'b0;
      end else begin
         cur_phase    = phase_ff;
         cur_count    = count_ff;
         cur_command  = command_ff;
         cur_flags    = flags_ff;
         cur_key_len  = key_len_ff;
         cur_key_left = key_left_ff;
         cur_val_len  = val_len_ff;
         cur_val_left = val_left_ff;
         cur_error    = error_ff;
         cur_cmd_high = cmd_high_ff;
      end
   end

   assign flags_base   = (cur_count != '0) ? cur_flags : '0;
   assign key_len_base = (cur_count != '0) ? cur_key_len : '0;
   assign val_len_base = (cur_count != '0) ? cur_val_len : '0;
   assign key_left_dec = (cur_key_left != '0) ? cur_key_left - len_type'(1) : cur_key_left;
   assign val_left_dec = (cur_val_left != '0) ? cur_val_left - len_type'(1) : cur_val_left;

   always_comb begin
      phase_in      = cur_phase;
      count_in      = cur_count;
      command_in    = cur_command;
      flags_in      = cur_flags;
      key_len_in    = cur_key_len;
      key_left_in   = cur_key_left;
      val_len_in    = cur_val_len;
      val_left_in   = cur_val_left;
      error_in      = cur_error;
      cmd_high_in   = cur_cmd_high;
      rsp_status_in = STATUS_NEED_MORE;
      rsp_kind_in   = KIND_VERSION;
      rsp_last_in   = 1'b0;

      if (cur_error) begin
         rsp_status_in = STATUS_DROPPED;
      end else begin
         unique case (cur_phase)
            PH_COMMAND: begin
               rsp_kind_in = KIND_COMMAND;
               if (cur_count < CMD_LAST_INDEX) begin
                  if (data_byte != BYTE_ZERO) begin
                     cmd_high_in = 1'b1;
                  end
                  count_in = cur_count + 3'd1;
               end else begin
                  rsp_last_in = 1'b1;
                  if (cur_cmd_high || data_byte > DATA_BITS'(CMD_PUT)) begin
                     rsp_status_in = STATUS_BAD_COMMAND;
                     error_in      = 1'b1;
                  end else begin
                     command_in = data_byte[1:0];
                     phase_in   = PH_FLAGS;
                  end
                  count_in    = '0;
                  cmd_high_in = 1'b0;
               end
            end
            PH_FLAGS: begin
               rsp_kind_in = KIND_FLAGS;
               flags_in    = WORD_BITS'({flags_base, data_byte});
               if (cur_count == WORD_LAST_INDEX) begin
                  rsp_last_in = 1'b1;
                  count_in    = '0;
                  phase_in    = PH_KEYLEN;
               end else begin
                  count_in = cur_count + 3'd1;
               end
            end
            PH_KEYLEN: begin
               rsp_kind_in = KIND_KEY_LEN;
               key_len_in  = LENGTH_BITS'({key_len_base, data_byte});
               if (cur_count == WORD_LAST_INDEX) begin
                  rsp_last_in = 1'b1;
                  count_in    = '0;
                  if (key_len_in != '0) begin
                     key_left_in = key_len_in;
                     phase_in    = PH_KEY;
                  end
               end else begin
                  count_in = cur_count + 3'd1;
               end
            end
            PH_KEY: begin
               rsp_kind_in = KIND_KEY_BYTE;
               key_left_in = key_left_dec;
               if (key_left_dec == '0) begin
                  rsp_last_in = 1'b1;
                  if (cur_command == CMD_GET) begin
                     rsp_status_in = STATUS_COMPLETE;
                     phase_in      = PH_VERSION;
                  end else begin
                     phase_in = PH_VALLEN;
                  end
               end
            end
            PH_VALLEN: begin
               rsp_kind_in = KIND_VALUE_LEN;
               val_len_in  = LENGTH_BITS'({val_len_base, data_byte});
               if (cur_count == WORD_LAST_INDEX) begin
                  rsp_last_in = 1'b1;
                  count_in    = '0;
                  if (val_len_in != '0) begin
                     val_left_in = val_len_in;
                     phase_in    = PH_VALUE;
                  end
               end else begin
                  count_in = cur_count + 3'd1;
               end
            end
            PH_VALUE: begin
               rsp_kind_in = KIND_VALUE_BYTE;
               val_left_in = val_left_dec;
               if (val_left_dec == '0) begin
                  rsp_last_in   = 1'b1;
                  rsp_status_in = STATUS_COMPLETE;
                  phase_in      = PH_VERSION;
               end
            end
            default: begin
               // version byte, also taken for the unused phase code
               rsp_kind_in = KIND_VERSION;
               rsp_last_in = 1'b1;
               command_in  = CMD_NOP;
               flags_in    = '0;
               key_len_in  = '0;
               key_left_in = '0;
               val_len_in  = '0;
               val_left_in = '0;
               count_in    = '0;
               cmd_high_in = 1'b0;
               if (data_byte != VERSION_OK) begin
                  rsp_status_in = STATUS_BAD_VERSION;
                  error_in      = 1'b1;
                  phase_in      = PH_VERSION;
               end else begin
                  phase_in = PH_COMMAND;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VERSION;
         count_ff     <= '0;
         command_ff   <= CMD_NOP;
         flags_ff     <= '0;
         key_len_ff   <= '0;
         key_left_ff  <= '0;
         val_len_ff   <= '0;
         val_left_ff  <= '0;
         error_ff     <= 1'b0;
         cmd_high_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            command_ff   <= command_in;
            flags_ff     <= flags_in;
            key_len_ff   <= key_len_in;
            key_left_ff  <= key_left_in;
            val_len_ff   <= val_len_in;
            val_left_ff  <= val_left_in;
            error_ff     <= error_in;
            cmd_high_ff  <= cmd_high_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_byte_ff   <= data_byte;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000,
                        WORD_BITS'(val_len_ff),
                        WORD_BITS'(key_len_ff),
                        flags_ff,
                        command_ff,
                        rsp_byte_ff,
                        rsp_status_ff};

   `KVRFP_ASSERT_NEXT(a_error_drops, clock, reset, accept && error_ff && !req_tuser,
      rsp_valid_ff && rsp_status_ff == STATUS_DROPPED, "byte not dropped after error")
   `KVRFP_ASSERT_NEXT(a_accept_fills_output, clock, reset, accept, rsp_valid_ff,
      "accepted byte produced no output transfer")
   `KVRFP_ASSERT(a_complete_is_last, clock, reset,
      !(rsp_valid_ff && rsp_status_ff == STATUS_COMPLETE) || rsp_last_ff,
      "request complete without last byte of field")
   `KVRFP_ASSERT(a_count_in_header, clock, reset,
      count_ff == '0 || phase_ff == PH_COMMAND || phase_ff == PH_FLAGS ||
      phase_ff == PH_KEYLEN || phase_ff == PH_VALLEN,
      "byte count left nonzero outside a header field")

endmodule
